>>> src/srp_pkg.sv
// Shared types and constants of the sector read-ahead planner.
`timescale 1ns / 1ps

package srp_pkg;

  // Prefetch block size and the window level at or below which a refill goes out.
  localparam int PREFETCH_BLOCK = 256;
  localparam int REFILL_LEVEL   = 256;

  localparam int SECTOR_W  = 32;
  localparam int COUNT_W   = 16;
  localparam int WIN_LEN_W = 10;
  localparam int RES_SLOTS = 3;
  localparam int SLOT_W    = 2;

  typedef enum logic {
    KIND_READ_REQ  = 1'b0,
    KIND_RECV_PLAN = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SECTOR_W-1:0]  start;
    logic [WIN_LEN_W-1:0] len;
  } win_t;

  typedef struct packed {
    kind_e                kind;
    logic [SECTOR_W-1:0]  first_sector;
    logic [COUNT_W-1:0]   sector_total;
    logic [WIN_LEN_W-1:0] discard_total;
    logic                 last_item;
  } res_t;

  typedef struct packed {
    win_t              win;
    logic [SLOT_W-1:0] num;
    res_t [RES_SLOTS-1:0] res;
  } plan_t;

endpackage

>>> src/srp_plan.sv
// Combinational planner: window hit test, trimming, widening, refill and result list.
`timescale 1ns / 1ps

module srp_plan import srp_pkg::*; (
  input  win_t                win_i,
  input  logic                readahead_i,
  input  logic [SECTOR_W-1:0] sec_i,
  input  logic [COUNT_W-1:0]  cnt_i,
  output plan_t               plan_o
);

  logic [SECTOR_W-1:0]  win_end;
  logic [SECTOR_W-1:0]  diff;
  logic [SECTOR_W-1:0]  req_end;
  logic                 hit;
  logic [WIN_LEN_W-1:0] discard;
  logic [WIN_LEN_W-1:0] coming;
  logic                 keep;
  win_t                 win1;
  win_t                 win2;
  win_t                 win3;
  logic                 need_req;
  logic [COUNT_W-1:0]   nreq;
  logic                 widen;
  logic                 refill;
  res_t                 req0;
  res_t                 req1;
  res_t                 plan;

  always_comb begin
    win_end = win_i.start + SECTOR_W'(win_i.len);
    diff    = sec_i - win_i.start;
    req_end = sec_i + SECTOR_W'(cnt_i);
    hit     = (sec_i >= win_i.start) && (sec_i < win_end);

    // The offset into a hit window is below its length, so it fits the length width.
    discard = hit ? diff[WIN_LEN_W-1:0] : win_i.len;
    coming  = hit ? (win_i.len - diff[WIN_LEN_W-1:0]) : '0;

    // The window survives only when it reaches past the caller's request.
    keep = hit && (COUNT_W'(coming) > cnt_i);
    win1.start = keep ? req_end : win_i.start;
    win1.len   = keep ? (coming - cnt_i[WIN_LEN_W-1:0]) : '0;

    need_req = COUNT_W'(coming) < cnt_i;
    nreq     = cnt_i - COUNT_W'(coming);
    widen    = need_req && readahead_i && (nreq < COUNT_W'(PREFETCH_BLOCK));
    win2 = win1;
    if (widen) begin
      win2.start = req_end;
      win2.len   = WIN_LEN_W'(PREFETCH_BLOCK) - nreq[WIN_LEN_W-1:0];
    end

    refill = readahead_i && (win2.len <= WIN_LEN_W'(REFILL_LEVEL));
    win3 = win2;
    if (refill) begin
      if (win2.len == '0) begin
        win3.start = req_end;
      end
      win3.len = win2.len + WIN_LEN_W'(PREFETCH_BLOCK);
    end

    req0.kind          = KIND_READ_REQ;
    req0.first_sector  = sec_i + SECTOR_W'(coming);
    req0.sector_total  = widen ? COUNT_W'(PREFETCH_BLOCK) : nreq;
    req0.discard_total = '0;
    req0.last_item     = 1'b0;

    req1.kind          = KIND_READ_REQ;
    req1.first_sector  = win3.start + SECTOR_W'(win2.len);
    req1.sector_total  = COUNT_W'(PREFETCH_BLOCK);
    req1.discard_total = '0;
    req1.last_item     = 1'b0;

    plan.kind          = KIND_RECV_PLAN;
    plan.first_sector  = sec_i;
    plan.sector_total  = cnt_i;
    plan.discard_total = discard;
    plan.last_item     = 1'b1;

    plan_o.res = '0;
    if (cnt_i == '0) begin
      // An empty request leaves the window alone and produces nothing.
      plan_o.win = win_i;
      plan_o.num = '0;
    end else begin
      plan_o.win = win3;
      case ({need_req, refill})
        2'b11: begin
          plan_o.num    = SLOT_W'(3);
          plan_o.res[0] = req0;
          plan_o.res[1] = req1;
          plan_o.res[2] = plan;
        end
        2'b10: begin
          plan_o.num    = SLOT_W'(2);
          plan_o.res[0] = req0;
          plan_o.res[1] = plan;
        end
        2'b01: begin
          plan_o.num    = SLOT_W'(2);
          plan_o.res[0] = req1;
          plan_o.res[1] = plan;
        end
        default: begin
          plan_o.num    = SLOT_W'(1);
          plan_o.res[0] = plan;
        end
      endcase
    end
  end

endmodule

>>> src/sector_readahead_planner.sv
// Top level of the sector read-ahead planner: input register, window state, result queue.
`timescale 1ns / 1ps

// Each nonzero read request (start sector, count) produces one, two or three
// result transfers on the master side: an optional read request for sectors
// the prefetch window does not hold, an optional refill request for the next
// prefetch block, and always a receive plan (tlast high) that tells how many
// stale prefetched sectors to drop before the caller's data. A request with a
// zero count is taken and produces no transfer. An accepted request waits in
// the input register until the result queue can take its results; the
// planner then updates the window and loads all of that request's results
// together into a three-entry result queue. The queue drains one result per
// cycle while the master side is ready, and the next request is loaded in the
// cycle its predecessor's last result is taken. The window register is updated
// on each load, so requests can follow each other back to back. The read-ahead
// enable should be written only while the planner is idle.

module sector_readahead_planner import srp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit 0 enables read-ahead widening and refills.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // [31:0] start_sector, [47:32] sector_count
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] first_sector, [47:32] sector_total, [57:48] discard_total, [63:58] zero
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,  // [0] result_kind
  output logic        m_axis_tlast_o   // last_item
);

  logic                readahead_q;
  logic                in_valid_q;
  logic [SECTOR_W-1:0] sec_q;
  logic [COUNT_W-1:0]  cnt_q;
  win_t                win_q;
  res_t [RES_SLOTS-1:0] res_q;
  logic [SLOT_W-1:0]   pend_q;
  logic [SLOT_W-1:0]   rd_q;

  plan_t plan;
  logic  out_xfer;
  logic  in_xfer;
  logic  load;
  res_t  head;

  srp_plan u_plan (
    .win_i      (win_q),
    .readahead_i(readahead_q),
    .sec_i      (sec_q),
    .cnt_i      (cnt_q),
    .plan_o     (plan)
  );

  // The queue can take a new result set once it is empty or its last entry leaves now.
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign load     = in_valid_q &&
                    ((pend_q == '0) || ((pend_q == SLOT_W'(1)) && m_axis_tready_i));
  assign s_axis_tready_o = !in_valid_q || load;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    case (rd_q)
      SLOT_W'(0): head = res_q[0];
      SLOT_W'(1): head = res_q[1];
      SLOT_W'(2): head = res_q[2];
      default:    head = res_q[0];
    endcase
  end

  assign m_axis_tvalid_o = pend_q != '0;
  assign m_axis_tdata_o  = {6'b0, head.discard_total, head.sector_total, head.first_sector};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readahead_q <= 1'b0;
      in_valid_q  <= 1'b0;
      win_q       <= '0;
      pend_q      <= '0;
      rd_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        readahead_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        win_q  <= plan.win;
        pend_q <= plan.num;
        rd_q   <= '0;
      end else if (out_xfer) begin
        pend_q <= pend_q - SLOT_W'(1);
        rd_q   <= rd_q + SLOT_W'(1);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sec_q <= s_axis_tdata_i[31:0];
      cnt_q <= s_axis_tdata_i[47:32];
    end
    if (load) begin
      res_q <= plan.res;
    end
  end

  // The receive plan is always the last entry of a result set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> pend_q == SLOT_W'(1))
    else $error("receive plan is not the last queued result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> pend_q != SLOT_W'(1))
    else $error("queue ends on a read request");

  // Read pointer and remaining entries never run past the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_q} + {1'b0, pend_q}) <= (SLOT_W + 1)'(RES_SLOTS))
    else $error("result queue overrun");

  // The window never grows beyond two prefetch blocks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q.len <= WIN_LEN_W'(2 * PREFETCH_BLOCK))
    else $error("window length out of range");

  // A loaded result set with results starts at the head of the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> rd_q == '0)
    else $error("result set not loaded at queue head");

endmodule
